>>> design/frvg_pkg.sv
// Shared constants and beat types for the frame RMS level detector.
`timescale 1ns / 1ps
package frvg_pkg;

  localparam int FRAME_MAX = 1024;

  localparam int SAMPLE_W = 16;
  localparam int LEVEL_W  = 24;
  localparam int ALPHA_W  = 17;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 2;

  // Count must hold FRAME_MAX itself; the square sum holds FRAME_MAX squares.
  localparam int CNT_W  = $clog2(FRAME_MAX + 1);
  localparam int SQ_W   = 2 * SAMPLE_W;
  localparam int SUM_W  = 2 * (SAMPLE_W - 1) + CNT_W;
  localparam int NUM_W  = SUM_W + 16;
  // Mean square times 65536 never exceeds 2^46, so 48 radicand bits suffice.
  localparam int RAD_W  = 2 * LEVEL_W;
  localparam int SREM_W = LEVEL_W + 2;
  localparam int HI_W   = LEVEL_W + 2;
  localparam int PROD_W = HI_W + ALPHA_W;
  localparam int STEP_W = $clog2(NUM_W);

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(65536);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(6554);
  localparam logic [PROD_W-1:0]  ROUND_HALF  = PROD_W'(32768);

  localparam logic [CFG_IDX_W-1:0] CFG_VOICE_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GATE_THR  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA     = CFG_IDX_W'(2);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       last_of_frame;
  } in_beat_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms_level;
    logic               voice_detected;
    logic               gate_closed;
    logic [LEVEL_W-1:0] noise_floor_level;
  } out_beat_t;

endpackage

>>> design/frame_rms_voice_gate_noise_floor_top.sv
// Frame RMS level detector with voice flag, noise gate and smoothed noise floor.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | sink      | in_valid_i/in_stall_o | in_beat_t (sample, last mark)
//   out     | source    | out_valid_o/out_stall_i | out_beat_t (rms, flags, floor)
//   cfg     | sink      | cfg_valid_i/cfg_ready_o | register index and data
//
// A sample that does not end its frame is squared, then accumulated.
// A frame-ending sample is squared and accumulated, then divided, passed
// through the square root, used in the floor update (multiply, round) and
// emitted; the floor multiply is skipped while the floor is still zero.
// The bit-serial divider produces one quotient bit per cycle.
// Reset clears accumulators, floor, thresholds, presets alpha; no output pending.
// A stalled result holds in the output register while the next frame builds.
`timescale 1ns / 1ps
module frame_rms_voice_gate_noise_floor_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  frvg_pkg::in_beat_t           in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output frvg_pkg::out_beat_t          out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [frvg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [frvg_pkg::CFG_W-1:0]   cfg_data_i
);
  import frvg_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_DIV,
    ST_SQRT,
    ST_MUL,
    ST_ROUND,
    ST_EMIT
  } state_e;

  state_e             state_q;
  logic [STEP_W-1:0]  step_q;
  logic [SUM_W-1:0]   sum_q;
  logic [CNT_W-1:0]   count_q;
  logic [LEVEL_W-1:0] nf_q;
  logic [LEVEL_W-1:0] voice_thr_q;
  logic [LEVEL_W-1:0] gate_thr_q;
  logic [ALPHA_W-1:0] alpha_q;
  logic               out_valid_q;
  out_beat_t          out_data_q;

  // Datapath registers
  logic [SQ_W-1:0]    sq_q;
  logic               last_q;
  logic [CNT_W:0]     div_rem_q;
  logic [NUM_W-1:0]   num_q;
  logic [RAD_W-1:0]   rad_q;
  logic [SREM_W-1:0]  srem_q;
  logic [LEVEL_W-1:0] root_q;
  logic [LEVEL_W-1:0] rms_q;
  logic [ALPHA_W-1:0] ma_q;
  logic [ALPHA_W-1:0] mb_q;
  logic [HI_W-1:0]    hi_q;
  logic [ALPHA_W-1:0] lo_q;

  logic               in_accept;
  logic               out_free;
  logic [SAMPLE_W-1:0] mag;
  logic [SUM_W-1:0]   sum_d;
  logic [CNT_W-1:0]   count_d;
  logic               frame_end;
  logic [CNT_W:0]     div_sh;
  logic               div_ge;
  logic [CNT_W:0]     div_rem_d;
  logic [NUM_W-1:0]   num_d;
  logic [SREM_W-1:0]  sq_sh;
  logic [SREM_W-1:0]  sq_trial;
  logic               sq_ge;
  logic [SREM_W-1:0]  srem_d;
  logic [LEVEL_W-1:0] root_d;
  logic [HI_W-1:0]    mul_sum;
  logic [PROD_W-1:0]  prod_rnd;
  logic [ALPHA_W-1:0] alpha_sat;
  logic [ALPHA_W-1:0] alpha_inv;
  logic               div_last;
  logic               sqrt_last;
  logic               mul_last;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    mag = in_data_i.sample[SAMPLE_W-1] ? SAMPLE_W'(~in_data_i.sample + 1'b1)
                                       : SAMPLE_W'(in_data_i.sample);
    sum_d     = sum_q + SUM_W'(sq_q);
    count_d   = count_q + 1'b1;
    frame_end = last_q || (count_d >= CNT_W'(FRAME_MAX));

    // Restoring divide: one quotient bit per cycle, shifted into num_q.
    div_sh    = {div_rem_q[CNT_W-1:0], num_q[NUM_W-1]};
    div_ge    = (div_sh >= {1'b0, count_q});
    div_rem_d = div_ge ? div_sh - {1'b0, count_q} : div_sh;
    num_d     = {num_q[NUM_W-2:0], div_ge};

    // Square root: two radicand bits in, one root bit out per cycle.
    sq_sh    = {srem_q[SREM_W-3:0], rad_q[RAD_W-1 -: 2]};
    sq_trial = {root_q, 2'b01};
    sq_ge    = (sq_sh >= sq_trial);
    srem_d   = sq_ge ? sq_sh - sq_trial : sq_sh;
    root_d   = {root_q[LEVEL_W-2:0], sq_ge};

    // Shift-add multiply of both weights at once, LSB of the weights first.
    mul_sum  = hi_q + (ma_q[0] ? HI_W'(rms_q) : '0) + (mb_q[0] ? HI_W'(nf_q) : '0);
    prod_rnd = {hi_q, lo_q} + ROUND_HALF;

    alpha_sat = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
    alpha_inv = ALPHA_ONE - alpha_sat;

    div_last  = (step_q == STEP_W'(NUM_W - 1));
    sqrt_last = (step_q == STEP_W'(LEVEL_W - 1));
    mul_last  = (step_q == STEP_W'(ALPHA_W - 1));
  end

  // Control state, accumulators, registers and the output beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      sum_q       <= '0;
      count_q     <= '0;
      nf_q        <= '0;
      voice_thr_q <= '0;
      gate_thr_q  <= '0;
      alpha_q     <= ALPHA_RESET;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_VOICE_THR: voice_thr_q <= cfg_data_i[LEVEL_W-1:0];
          CFG_GATE_THR:  gate_thr_q  <= cfg_data_i[LEVEL_W-1:0];
          CFG_ALPHA:     alpha_q     <= cfg_data_i[ALPHA_W-1:0];
          default: ;
        endcase
      end
      case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            state_q <= ST_ACCUM;
          end
        end
        ST_ACCUM: begin
          sum_q   <= sum_d;
          count_q <= count_d;
          step_q  <= '0;
          state_q <= frame_end ? ST_DIV : ST_IDLE;
        end
        ST_DIV: begin
          if (div_last) begin
            step_q  <= '0;
            state_q <= ST_SQRT;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_SQRT: begin
          if (sqrt_last) begin
            step_q <= '0;
            // While the floor is zero, it takes the frame level directly.
            if (nf_q == '0) begin
              nf_q    <= root_d;
              state_q <= ST_EMIT;
            end else begin
              state_q <= ST_MUL;
            end
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_MUL: begin
          if (mul_last) begin
            step_q  <= '0;
            state_q <= ST_ROUND;
          end else begin
            step_q <= step_q + 1'b1;
          end
        end
        ST_ROUND: begin
          nf_q    <= prod_rnd[16 +: LEVEL_W];
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_data_q.rms_level         <= rms_q;
            out_data_q.voice_detected    <= (rms_q > voice_thr_q);
            out_data_q.gate_closed       <= (rms_q < gate_thr_q);
            out_data_q.noise_floor_level <= nf_q;
            sum_q   <= '0;
            count_q <= '0;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Datapath shift registers, no reset
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          sq_q   <= SQ_W'(mag) * SQ_W'(mag);
          last_q <= in_data_i.last_of_frame;
        end
      end
      ST_ACCUM: begin
        div_rem_q <= '0;
        num_q     <= {sum_d, 16'b0};
      end
      ST_DIV: begin
        div_rem_q <= div_rem_d;
        num_q     <= num_d;
        if (div_last) begin
          rad_q  <= num_d[RAD_W-1:0];
          srem_q <= '0;
          root_q <= '0;
        end
      end
      ST_SQRT: begin
        rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
        srem_q <= srem_d;
        root_q <= root_d;
        if (sqrt_last) begin
          rms_q <= root_d;
          ma_q  <= alpha_sat;
          mb_q  <= alpha_inv;
          hi_q  <= '0;
          lo_q  <= '0;
        end
      end
      ST_MUL: begin
        hi_q <= {1'b0, mul_sum[HI_W-1:1]};
        lo_q <= {mul_sum[0], lo_q[ALPHA_W-1:1]};
        ma_q <= {1'b0, ma_q[ALPHA_W-1:1]};
        mb_q <= {1'b0, mb_q[ALPHA_W-1:1]};
      end
      default: ;
    endcase
  end

endmodule

>>> design/frvg_checker.sv
// Port-level checks for the frame RMS level detector, bound to the top level.
`timescale 1ns / 1ps
module frvg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input frvg_pkg::out_beat_t out_data_o,
  input logic                out_valid_o,
  input logic                out_stall_i
);
  import frvg_pkg::*;

  // A stalled output beat stays and holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled output beat changed");

  // Frame level never exceeds full scale in Q.8.
  a_rms_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.rms_level <= LEVEL_W'(8388608))
    else $error("rms level above full scale");

  // Each accepted sample is accumulated before the next is taken.
  a_accum_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken during accumulate");

  // A new result only appears out of the busy frame-end sequence.
  a_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result appeared while input side idle");

endmodule

bind frame_rms_voice_gate_noise_floor_top frvg_checker u_frvg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_data_o  (out_data_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);
